// File: hdl/uce_pkg.sv
// Shared types and constants for the URL component extractor.
`default_nettype none

package uce_pkg;

    localparam int N_MARKS = 10;

    localparam int M_SLASH    = 0;
    localparam int M_QUEST    = 1;
    localparam int M_HASH     = 2;
    localparam int M_AT       = 3;
    localparam int M_COLON    = 4;
    localparam int M_AT_COLON = 5;
    localparam int M_AT_SLASH = 6;
    localparam int M_SL_QUEST = 7;
    localparam int M_SL_HASH  = 8;
    localparam int M_QU_HASH  = 9;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef enum logic [2:0] {
        PART_AUTHORITY = 3'd0,
        PART_FILE      = 3'd1,
        PART_HOST      = 3'd2,
        PART_PATH      = 3'd3,
        PART_PROTOCOL  = 3'd4,
        PART_QUERY     = 3'd5,
        PART_REF       = 3'd6,
        PART_USERINFO  = 3'd7
    } part_sel_t;

    typedef enum logic [1:0] {
        SCH_IDLE   = 2'd0,
        SCH_COLON  = 2'd1,
        SCH_SLASH1 = 2'd2
    } scheme_st_t;

    typedef struct packed {
        logic               overflow;
        logic               first_valid;
        logic               scheme_valid;
        logic [N_MARKS-1:0] mark_valid;
    } scan_flags_t;

endpackage

`default_nettype wire

// File: hdl/uce_scan.sv
// Per-URL scan state: trimmed bounds, scheme search and delimiter positions.
`default_nettype none

module uce_scan
    import uce_pkg::*;
#(
    parameter int MAX_URL_BYTES = 65536,
    localparam int POS_W = $clog2(MAX_URL_BYTES + 1)
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       url_byte,
    input  logic             last_byte,
    output scan_flags_t      flags,
    output logic [POS_W-1:0] first_pos,
    output logic [POS_W-1:0] last_pos,
    output logic [POS_W-1:0] scheme_pos,
    output logic [POS_W-1:0] mark_pos [N_MARKS]
);

    logic [POS_W-1:0]   idx_reg;
    logic [POS_W-1:0]   idx_next;
    scan_flags_t        flags_reg;
    logic [POS_W-1:0]   first_pos_reg;
    logic [POS_W-1:0]   last_pos_reg;
    logic [POS_W-1:0]   scheme_pos_reg;
    logic [POS_W-1:0]   mark_pos_reg [N_MARKS];
    scheme_st_t         sch_reg;
    scheme_st_t         sch_next;
    logic               take;
    logic [N_MARKS-1:0] mark_hit;

    assign take = (idx_reg < POS_W'(MAX_URL_BYTES));
    assign idx_next = take ? idx_reg + POS_W'(1) : idx_reg;

    always_comb
    begin
        sch_next = sch_reg;
        if (take && !flags_reg.scheme_valid)
        begin
            if (url_byte == CH_COLON)
            begin
                sch_next = SCH_COLON;
            end
            else if (url_byte == CH_SLASH && sch_reg == SCH_COLON)
            begin
                sch_next = SCH_SLASH1;
            end
            else
            begin
                sch_next = SCH_IDLE;
            end
        end
    end

    always_comb
    begin
        mark_hit = '0;
        if (flags_reg.scheme_valid)
        begin
            case (url_byte)
                CH_SLASH:
                begin
                    mark_hit[M_AT_SLASH] = flags_reg.mark_valid[M_AT];
                    mark_hit[M_SLASH]    = 1'b1;
                end
                CH_QUEST:
                begin
                    mark_hit[M_SL_QUEST] = flags_reg.mark_valid[M_SLASH];
                    mark_hit[M_QUEST]    = 1'b1;
                end
                CH_HASH:
                begin
                    mark_hit[M_SL_HASH] = flags_reg.mark_valid[M_SLASH];
                    mark_hit[M_QU_HASH] = flags_reg.mark_valid[M_QUEST];
                    mark_hit[M_HASH]    = 1'b1;
                end
                CH_AT:
                begin
                    mark_hit[M_AT] = 1'b1;
                end
                CH_COLON:
                begin
                    mark_hit[M_AT_COLON] = flags_reg.mark_valid[M_AT];
                    mark_hit[M_COLON]    = 1'b1;
                end
                default:
                begin
                    mark_hit = '0;
                end
            endcase
        end
    end

    // The outputs show the state with the current byte already folded in.
    always_comb
    begin
        flags      = flags_reg;
        first_pos  = first_pos_reg;
        last_pos   = last_pos_reg;
        scheme_pos = scheme_pos_reg;
        mark_pos   = mark_pos_reg;
        if (!take)
        begin
            flags.overflow = 1'b1;
        end
        else
        begin
            if (url_byte != CH_SPACE)
            begin
                if (!flags_reg.first_valid)
                begin
                    flags.first_valid = 1'b1;
                    first_pos         = idx_reg;
                end
                last_pos = idx_reg;
            end
            if (!flags_reg.scheme_valid && sch_reg == SCH_SLASH1 && url_byte == CH_SLASH)
            begin
                flags.scheme_valid = 1'b1;
                scheme_pos         = idx_reg - POS_W'(2);
            end
            for (int k = 0; k < N_MARKS; k++)
            begin
                if (mark_hit[k] && !flags_reg.mark_valid[k])
                begin
                    flags.mark_valid[k] = 1'b1;
                    mark_pos[k]         = idx_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            flags_reg    <= '0;
            last_pos_reg <= '0;
            sch_reg      <= SCH_IDLE;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                idx_reg      <= '0;
                flags_reg    <= '0;
                last_pos_reg <= '0;
                sch_reg      <= SCH_IDLE;
            end
            else
            begin
                idx_reg      <= idx_next;
                flags_reg    <= flags;
                last_pos_reg <= last_pos;
                sch_reg      <= sch_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && !last_byte)
        begin
            first_pos_reg  <= first_pos;
            scheme_pos_reg <= scheme_pos;
            mark_pos_reg   <= mark_pos;
        end
    end

endmodule

`default_nettype wire

// File: hdl/uce_select.sv
// Start and length of the selected URL part from the scan state.
`default_nettype none

module uce_select
    import uce_pkg::*;
#(
    parameter int MAX_URL_BYTES = 65536,
    localparam int POS_W = $clog2(MAX_URL_BYTES + 1)
)(
    input  part_sel_t        part_sel,
    input  scan_flags_t      flags,
    input  logic [POS_W-1:0] first_pos,
    input  logic [POS_W-1:0] last_pos,
    input  logic [POS_W-1:0] scheme_pos,
    input  logic [POS_W-1:0] mark_pos [N_MARKS],
    output logic             found,
    output logic [15:0]      start,
    output logic [15:0]      length
);

    localparam int OUT_W = (POS_W > 16) ? POS_W : 16;

    logic [POS_W-1:0] p;
    logic [POS_W-1:0] te;
    logic [POS_W-1:0] s;
    logic [POS_W-1:0] e;
    logic [POS_W-1:0] e_clamp;
    logic [OUT_W-1:0] s_wide;
    logic [OUT_W-1:0] len_wide;
    logic [N_MARKS-1:0] mv;

    assign mv = flags.mark_valid;
    assign p  = scheme_pos + POS_W'(3);
    assign te = last_pos + POS_W'(1);

    always_comb
    begin
        found = 1'b0;
        s     = '0;
        e     = '0;
        if (!flags.overflow && flags.scheme_valid)
        begin
            found = 1'b1;
            case (part_sel)
                PART_AUTHORITY:
                begin
                    s = p;
                    e = mv[M_SLASH] ? mark_pos[M_SLASH] : te;
                end
                PART_FILE:
                begin
                    if (mv[M_SLASH])
                    begin
                        s = mark_pos[M_SLASH];
                        e = mv[M_SL_HASH] ? mark_pos[M_SL_HASH] : te;
                    end
                end
                PART_PATH:
                begin
                    if (mv[M_SLASH])
                    begin
                        s = mark_pos[M_SLASH];
                        e = mv[M_SL_QUEST] ? mark_pos[M_SL_QUEST] :
                            mv[M_SL_HASH]  ? mark_pos[M_SL_HASH]  : te;
                    end
                end
                PART_HOST:
                begin
                    if (mv[M_AT])
                    begin
                        s = mark_pos[M_AT] + POS_W'(1);
                        e = mv[M_AT_COLON] ? mark_pos[M_AT_COLON] :
                            mv[M_AT_SLASH] ? mark_pos[M_AT_SLASH] : te;
                    end
                    else
                    begin
                        s = p;
                        e = mv[M_COLON] ? mark_pos[M_COLON] :
                            mv[M_SLASH] ? mark_pos[M_SLASH] : te;
                    end
                end
                PART_PROTOCOL:
                begin
                    s = first_pos;
                    e = scheme_pos;
                end
                PART_QUERY:
                begin
                    if (mv[M_QUEST])
                    begin
                        s = mark_pos[M_QUEST] + POS_W'(1);
                        e = mv[M_QU_HASH] ? mark_pos[M_QU_HASH] : te;
                    end
                    else
                    begin
                        found = 1'b0;
                    end
                end
                PART_REF:
                begin
                    if (mv[M_HASH])
                    begin
                        s = mark_pos[M_HASH] + POS_W'(1);
                        e = te;
                    end
                    else
                    begin
                        found = 1'b0;
                    end
                end
                PART_USERINFO:
                begin
                    if (mv[M_AT])
                    begin
                        s = p;
                        e = mark_pos[M_AT];
                    end
                    else
                    begin
                        found = 1'b0;
                    end
                end
                default:
                begin
                    found = 1'b0;
                end
            endcase
        end
    end

    assign e_clamp  = (e < s) ? s : e;
    assign s_wide   = OUT_W'(s);
    assign len_wide = OUT_W'(e_clamp - s);
    assign start    = s_wide[15:0];
    assign length   = len_wide[15:0];

endmodule

`default_nettype wire

// File: hdl/url_component_extractor.sv
// Top level of the URL component extractor.
//
// A URL enters one byte per word on the byte channel (url_byte, last_byte,
// byte_valid, byte_stall); last_byte marks its final byte. The part chosen
// by part_select (the user writes it through part_select_we only while the
// block is idle; the block does not enforce this) leaves as one word on the
// part channel (part_found, part_start, part_length, too_long, part_valid,
// part_stall) for each URL. Throughput is one byte per cycle, back to back
// across URL boundaries, except while a final byte waits on a stalled result.
// Each byte passes an input register and then updates the scan state; the
// result word is registered in the output register as the final byte leaves
// the input register, and the part is picked from the scan state in the same
// cycle that the final byte updates it. Reset clears the scan index, flags,
// last position and scheme state, the output valid flag, and sets part_select
// to authority. While the receiver stalls, the result word holds and bytes
// that are not final keep flowing; a final byte waits in the input register,
// and byte_stall rises until the result word is taken.
`default_nettype none

module url_component_extractor
    import uce_pkg::*;
#(
    parameter int MAX_URL_BYTES = 65536
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  url_byte,
    input  logic        last_byte,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic        part_select_we,
    input  logic [2:0]  part_select,
    output logic        part_found,
    output logic [15:0] part_start,
    output logic [15:0] part_length,
    output logic        too_long,
    output logic        part_valid,
    input  logic        part_stall
);

    localparam int POS_W = $clog2(MAX_URL_BYTES + 1);

    part_sel_t        part_sel_reg;
    logic             in_valid_reg;
    logic             in_valid_next;
    logic [7:0]       in_byte_reg;
    logic             in_last_reg;
    logic             advance;
    logic             accept;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             found_reg;
    logic [15:0]      start_reg;
    logic [15:0]      length_reg;
    logic             too_long_reg;

    scan_flags_t      flags;
    logic [POS_W-1:0] first_pos;
    logic [POS_W-1:0] last_pos;
    logic [POS_W-1:0] scheme_pos;
    logic [POS_W-1:0] mark_pos [N_MARKS];
    logic             sel_found;
    logic [15:0]      sel_start;
    logic [15:0]      sel_length;

    assign advance        = in_valid_reg && !(in_last_reg && out_valid_reg && part_stall);
    assign byte_stall     = in_valid_reg && !advance;
    assign accept         = byte_valid && !byte_stall;
    assign in_valid_next  = accept || (in_valid_reg && !advance);
    assign out_valid_next = (advance && in_last_reg) || (out_valid_reg && part_stall);

    uce_scan #(
        .MAX_URL_BYTES(MAX_URL_BYTES)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .url_byte  (in_byte_reg),
        .last_byte (in_last_reg),
        .flags     (flags),
        .first_pos (first_pos),
        .last_pos  (last_pos),
        .scheme_pos(scheme_pos),
        .mark_pos  (mark_pos)
    );

    uce_select #(
        .MAX_URL_BYTES(MAX_URL_BYTES)
    ) u_select (
        .part_sel  (part_sel_reg),
        .flags     (flags),
        .first_pos (first_pos),
        .last_pos  (last_pos),
        .scheme_pos(scheme_pos),
        .mark_pos  (mark_pos),
        .found     (sel_found),
        .start     (sel_start),
        .length    (sel_length)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_sel_reg  <= PART_AUTHORITY;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (part_select_we)
            begin
                part_sel_reg <= part_sel_t'(part_select);
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= url_byte;
            in_last_reg <= last_byte;
        end
        if (advance && in_last_reg)
        begin
            found_reg    <= sel_found;
            start_reg    <= sel_start;
            length_reg   <= sel_length;
            too_long_reg <= flags.overflow;
        end
    end

    assign part_valid  = out_valid_reg;
    assign part_found  = found_reg;
    assign part_start  = start_reg;
    assign part_length = length_reg;
    assign too_long    = too_long_reg;

    a_rise_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && in_last_reg))
        else $error("Result word appeared without a final byte.");

    a_too_long_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && too_long_reg) |->
            (!found_reg && start_reg == 16'd0 && length_reg == 16'd0))
        else $error("Overlong URL reported a part.");

    a_last_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && in_last_reg && out_valid_reg && part_stall) |-> !advance)
        else $error("Final byte advanced over a pending result word.");

    a_held_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && part_stall) |=> (out_valid_reg && $stable(start_reg)
            && $stable(length_reg) && $stable(found_reg)))
        else $error("Stalled result word changed.");

endmodule

`default_nettype wire
